// ===== design/bts_pkg.sv =====
`timescale 1ns / 1ps
package bts_pkg;

    localparam int FRAC       = 16;
    localparam int PIX_W      = 12;
    localparam int QUO_W      = PIX_W + FRAC;
    localparam int DIV_STAGES = QUO_W;
    localparam int Q_DEPTH    = 4;
    localparam logic [12:0] SCREEN_MAX = 13'd4096;

    typedef enum logic [2:0] {
        CFG_TEX_W,
        CFG_TEX_H,
        CFG_SCR_W,
        CFG_SCR_H,
        CFG_OFF_X,
        CFG_OFF_Y,
        CFG_ZOOM_X,
        CFG_ZOOM_Y
    } t_cfg_idx;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef struct packed {
        logic [8:0]         tex_w;
        logic [8:0]         tex_h;
        logic [12:0]        scr_w;
        logic [12:0]        scr_h;
        logic signed [15:0] off_x;
        logic signed [15:0] off_y;
        logic [15:0]        zoom_x;
        logic [15:0]        zoom_y;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [15:0] index;
        logic [31:0] value;
        logic [11:0] px;
        logic [11:0] py;
    } t_req;

    // in_tex: [0] top-left, [1] top-right, [2] bottom-left, [3] bottom-right
    typedef struct packed {
        t_action     action;
        logic [15:0] addr_t;
        logic [15:0] addr_b;
        logic [31:0] value;
        logic [11:0] px;
        logic [11:0] py;
        logic [3:0]  in_tex;
        logic [7:0]  wx;
        logic [7:0]  wy;
    } t_job;

endpackage

// ===== design/bts_div.sv =====
`timescale 1ns / 1ps
module bts_div import bts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PIX_W-1:0]  i_pix,
    input  logic [12:0]       i_den,
    output logic [QUO_W-1:0]  o_quo
);

    logic [12:0]      r_rem [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];
    logic [PIX_W-1:0] r_pix [DIV_STAGES];

    // restoring division of (pix << FRAC) by den, one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic [12:0]      p_rem;
        logic [QUO_W-1:0] p_quo;
        logic [PIX_W-1:0] p_pix;
        logic             nb;
        logic [12:0]      t;
        logic             ge;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_pix = i_pix;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_quo = r_quo[k-1];
            assign p_pix = r_pix[k-1];
        end

        if (BIT >= FRAC) begin : g_num
            assign nb = p_pix[BIT-FRAC];
        end else begin : g_low
            assign nb = 1'b0;
        end

        // remainder stays below den <= 4096, so 12 bits carry it
        assign t  = {p_rem[11:0], nb};
        assign ge = (t >= i_den);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? (t - i_den) : t;
                r_quo[k] <= {p_quo[QUO_W-2:0], ge};
                r_pix[k] <= p_pix;
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// ===== design/bts_front.sv =====
`timescale 1ns / 1ps
module bts_front import bts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_ready,
    input  logic i_space,
    output logic o_push,
    output t_job o_job
);

    localparam int SUM_W = QUO_W + 2;
    localparam int M1_W  = SUM_W + 17;
    localparam int M2_W  = M1_W + 10;
    localparam int U_W   = M2_W - 12 + 1;
    localparam int C_W   = U_W - FRAC;
    localparam int OFF_PAD = SUM_W - 16 - (FRAC - 12);

    logic en;

    logic r_v0;
    t_req r_p0;
    logic r_dv [DIV_STAGES];
    t_req r_dp [DIV_STAGES];
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_req r_p1, r_p2, r_p3, r_p4;

    logic [12:0]      den_x, den_y;
    logic [QUO_W-1:0] quo_x, quo_y;

    logic signed [SUM_W-1:0] r_sx, r_sy, n_sx, n_sy;
    logic signed [M1_W-1:0]  r_mx, r_my;
    logic signed [M2_W-1:0]  r_qx, r_qy;
    logic signed [U_W-1:0]   n_u, n_v;
    logic [23:0]             n_tx, n_ty;
    logic signed [C_W-1:0]   r_cx, r_cy;
    logic [7:0]              r_wx, r_wy;

    logic signed [C_W-1:0]   cx1, cy1, wext, hext;
    logic [24:0]             rowoff;
    logic [15:0]             addr_t;
    t_job                    r_job, n_job;

    assign en      = !r_v5 || i_space;
    assign o_ready = en;
    assign o_push  = r_v5 && i_space;
    assign o_job   = r_job;

    // screen divisor: zero counts as one, large values clamp
    always_comb begin
        den_x = (i_cfg.scr_w == '0) ? 13'd1
              : ((i_cfg.scr_w > SCREEN_MAX) ? SCREEN_MAX : i_cfg.scr_w);
        den_y = (i_cfg.scr_h == '0) ? 13'd1
              : ((i_cfg.scr_h > SCREEN_MAX) ? SCREEN_MAX : i_cfg.scr_h);
    end

    bts_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_pix (r_p0.px),
        .i_den (den_x),
        .o_quo (quo_x)
    );

    bts_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_pix (r_p0.py),
        .i_den (den_y),
        .o_quo (quo_y)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) r_dv[k] <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v0    <= i_valid;
            r_dv[0] <= r_v0;
            for (int k = 1; k < DIV_STAGES; k++) r_dv[k] <= r_dv[k-1];
            r_v1 <= r_dv[DIV_STAGES-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // normalized coordinate plus offset, Q.FRAC
    always_comb begin
        n_sx = $signed({2'b00, quo_x})
             + $signed({{OFF_PAD{i_cfg.off_x[15]}}, i_cfg.off_x, {(FRAC-12){1'b0}}});
        n_sy = $signed({2'b00, quo_y})
             + $signed({{OFF_PAD{i_cfg.off_y[15]}}, i_cfg.off_y, {(FRAC-12){1'b0}}});
    end

    // floor of the Q.12 product, minus half a texel
    always_comb begin
        n_u  = U_W'(r_qx >>> 12) - $signed(U_W'(1) << (FRAC - 1));
        n_v  = U_W'(r_qy >>> 12) - $signed(U_W'(1) << (FRAC - 1));
        n_tx = {n_u[FRAC-1:0], 8'h00} - {8'h00, n_u[FRAC-1:0]};
        n_ty = {n_v[FRAC-1:0], 8'h00} - {8'h00, n_v[FRAC-1:0]};
    end

    // neighbour range checks and store address
    always_comb begin
        cx1    = r_cx + C_W'(1);
        cy1    = r_cy + C_W'(1);
        wext   = $signed(C_W'(i_cfg.tex_w));
        hext   = $signed(C_W'(i_cfg.tex_h));
        rowoff = r_cy[15:0] * i_cfg.tex_w;
        addr_t = rowoff[15:0] + r_cx[15:0];

        n_job.action    = r_p4.action;
        n_job.value     = r_p4.value;
        n_job.px        = r_p4.px;
        n_job.py        = r_p4.py;
        n_job.wx        = r_wx;
        n_job.wy        = r_wy;
        n_job.in_tex[0] = !r_cx[C_W-1] && (r_cx < wext) && !r_cy[C_W-1] && (r_cy < hext);
        n_job.in_tex[1] = !cx1[C_W-1]  && (cx1 < wext)  && !r_cy[C_W-1] && (r_cy < hext);
        n_job.in_tex[2] = !r_cx[C_W-1] && (r_cx < wext) && !cy1[C_W-1]  && (cy1 < hext);
        n_job.in_tex[3] = !cx1[C_W-1]  && (cx1 < wext)  && !cy1[C_W-1]  && (cy1 < hext);
        if (r_p4.action == ACT_WRITE) begin
            n_job.addr_t = r_p4.index;
            n_job.addr_b = r_p4.index;
        end else begin
            n_job.addr_t = addr_t;
            n_job.addr_b = addr_t + 16'(i_cfg.tex_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0    <= i_req;
            r_dp[0] <= r_p0;
            for (int k = 1; k < DIV_STAGES; k++) r_dp[k] <= r_dp[k-1];
            r_p1  <= r_dp[DIV_STAGES-1];
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_p2  <= r_p1;
            r_mx  <= r_sx * $signed({1'b0, i_cfg.zoom_x});
            r_my  <= r_sy * $signed({1'b0, i_cfg.zoom_y});
            r_p3  <= r_p2;
            r_qx  <= r_mx * $signed({1'b0, i_cfg.tex_w});
            r_qy  <= r_my * $signed({1'b0, i_cfg.tex_h});
            r_p4  <= r_p3;
            r_cx  <= n_u[U_W-1:FRAC];
            r_cy  <= n_v[U_W-1:FRAC];
            r_wx  <= n_tx[23:16];
            r_wy  <= n_ty[23:16];
            r_job <= n_job;
        end
    end

endmodule

// ===== design/bts_queue.sv =====
`timescale 1ns / 1ps
module bts_queue import bts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_space,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int QA = $clog2(Q_DEPTH);

    t_job          r_mem [Q_DEPTH];
    logic [QA-1:0] r_wp, r_rp;
    logic [QA:0]   r_cnt;

    assign o_space = (r_cnt != (QA+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QA'(1);
            if (i_pop)  r_rp <= r_rp + QA'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (QA+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (QA+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== design/bts_back.sv =====
`timescale 1ns / 1ps
module bts_back import bts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [11:0] o_x,
    output logic [11:0] o_y,
    output logic [31:0] o_color
);

    localparam int BANK_DEPTH = 32768;

    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input logic [7:0] w);
        logic [31:0] res;
        logic [15:0] x;
        logic [16:0] s;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            x = a[8*c +: 8] * (8'd255 - w) + b[8*c +: 8] * w;
            // exact x / 255 for x up to 255 * 255, the largest blend sum
            s = 17'(x) + 17'(x >> 8) + 17'd1;
            res[8*c +: 8] = s[15:8];
        end
        return res;
    endfunction

    // 2x2 banks: top and bottom copies, each split by address parity
    logic [31:0] r_mem_te [BANK_DEPTH];
    logic [31:0] r_mem_to [BANK_DEPTH];
    logic [31:0] r_mem_be [BANK_DEPTH];
    logic [31:0] r_mem_bo [BANK_DEPTH];
    logic [31:0] r_q_te, r_q_to, r_q_be, r_q_bo;

    logic        en, wr, rd;
    logic [15:0] at1, ab1;
    logic [14:0] a_te, a_to, a_be, a_bo;
    logic        we_e, we_o;

    logic        r_b1v, r_b1_ts, r_b1_bs;
    logic [3:0]  r_b1_in;
    logic [7:0]  r_b1_wx, r_b1_wy;
    logic [11:0] r_b1_x, r_b1_y;

    logic [31:0] tl, tr, bl, br;
    logic        r_b2v;
    logic [31:0] r_top, r_bot;
    logic [7:0]  r_b2_wy;
    logic [11:0] r_b2_x, r_b2_y;

    logic        r_ov;
    logic [11:0] r_ox, r_oy;
    logic [31:0] r_oc;

    assign en    = !r_ov || i_tready;
    assign o_pop = en && i_valid;
    assign wr    = o_pop && (i_job.action == ACT_WRITE);
    assign rd    = o_pop && (i_job.action == ACT_SAMPLE);
    assign we_e  = wr && !i_job.addr_t[0];
    assign we_o  = wr && i_job.addr_t[0];

    always_comb begin
        at1 = i_job.addr_t + 16'd1;
        ab1 = i_job.addr_b + 16'd1;
        if (wr) begin
            a_te = i_job.addr_t[15:1];
            a_to = i_job.addr_t[15:1];
            a_be = i_job.addr_t[15:1];
            a_bo = i_job.addr_t[15:1];
        end else begin
            a_te = i_job.addr_t[0] ? at1[15:1] : i_job.addr_t[15:1];
            a_to = i_job.addr_t[0] ? i_job.addr_t[15:1] : at1[15:1];
            a_be = i_job.addr_b[0] ? ab1[15:1] : i_job.addr_b[15:1];
            a_bo = i_job.addr_b[0] ? i_job.addr_b[15:1] : ab1[15:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_e) r_mem_te[a_te] <= i_job.value;
        if (rd)   r_q_te <= r_mem_te[a_te];
    end

    always_ff @(posedge i_clk) begin
        if (we_o) r_mem_to[a_to] <= i_job.value;
        if (rd)   r_q_to <= r_mem_to[a_to];
    end

    always_ff @(posedge i_clk) begin
        if (we_e) r_mem_be[a_be] <= i_job.value;
        if (rd)   r_q_be <= r_mem_be[a_be];
    end

    always_ff @(posedge i_clk) begin
        if (we_o) r_mem_bo[a_bo] <= i_job.value;
        if (rd)   r_q_bo <= r_mem_bo[a_bo];
    end

    // left texel sits in the odd bank when the row address is odd
    always_comb begin
        tl = r_b1_ts ? r_q_to : r_q_te;
        tr = r_b1_ts ? r_q_te : r_q_to;
        bl = r_b1_bs ? r_q_bo : r_q_be;
        br = r_b1_bs ? r_q_be : r_q_bo;
        if (!r_b1_in[0]) tl = '0;
        if (!r_b1_in[1]) tr = '0;
        if (!r_b1_in[2]) bl = '0;
        if (!r_b1_in[3]) br = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1v <= 1'b0;
            r_b2v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_b1v <= rd;
            r_b2v <= r_b1v;
            r_ov  <= r_b2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_ts <= i_job.addr_t[0];
            r_b1_bs <= i_job.addr_b[0];
            r_b1_in <= i_job.in_tex;
            r_b1_wx <= i_job.wx;
            r_b1_wy <= i_job.wy;
            r_b1_x  <= i_job.px;
            r_b1_y  <= i_job.py;
            r_top   <= blend(tl, tr, r_b1_wx);
            r_bot   <= blend(bl, br, r_b1_wx);
            r_b2_wy <= r_b1_wy;
            r_b2_x  <= r_b1_x;
            r_b2_y  <= r_b1_y;
            r_oc    <= blend(r_top, r_bot, r_b2_wy);
            r_ox    <= r_b2_x;
            r_oy    <= r_b2_y;
        end
    end

    assign o_tvalid = r_ov;
    assign o_x      = r_ox;
    assign o_y      = r_oy;
    assign o_color  = r_oc;

endmodule

// ===== design/bilinear_texture_sampler_core.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: texel_index, texel_value, pixel_x, pixel_y;
//                                       s_tuser: action
// m_*       out  m_tvalid / m_tready    m_tdata: out_x, out_y, color
// i_cfg_*   in   i_cfg_we               i_cfg_idx selects the register, i_cfg_wdata its value
//
// one transaction per cycle sustained while m_* accepts results; each sample passes
// through the 28-stage pipelined coordinate divider, then the scaling and fetch stages
// reset is synchronous and clears only control state; the texel store is not cleared
// a stall on m_* freezes the back end, the 4-entry queue fills, then the front end
// holds and s_tready drops; texel writes flow through the same order as samples
module bilinear_texture_sampler_core import bts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [15:0] texel_index, [47:16] texel_value,
                                   // [59:48] pixel_x, [71:60] pixel_y
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [11:0] out_x, [23:12] out_y, [55:24] color
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg r_cfg;
    t_req req;
    t_job f_job, q_job;
    logic f_push, q_space, q_valid, b_pop;
    logic [11:0] o_x, o_y;
    logic [31:0] o_color;

    // configuration registers; write them only while the block is idle, it does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_w  <= 9'd256;
            r_cfg.tex_h  <= 9'd256;
            r_cfg.scr_w  <= 13'd640;
            r_cfg.scr_h  <= 13'd480;
            r_cfg.off_x  <= '0;
            r_cfg.off_y  <= '0;
            r_cfg.zoom_x <= 16'd4096;
            r_cfg.zoom_y <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TEX_W:  r_cfg.tex_w  <= i_cfg_wdata[8:0];
                CFG_TEX_H:  r_cfg.tex_h  <= i_cfg_wdata[8:0];
                CFG_SCR_W:  r_cfg.scr_w  <= i_cfg_wdata[12:0];
                CFG_SCR_H:  r_cfg.scr_h  <= i_cfg_wdata[12:0];
                CFG_OFF_X:  r_cfg.off_x  <= i_cfg_wdata;
                CFG_OFF_Y:  r_cfg.off_y  <= i_cfg_wdata;
                CFG_ZOOM_X: r_cfg.zoom_x <= i_cfg_wdata;
                CFG_ZOOM_Y: r_cfg.zoom_y <= i_cfg_wdata;
            endcase
        end
    end

    // unpack the input transaction
    always_comb begin
        req.action = t_action'(s_tuser[0]);
        req.index  = s_tdata[15:0];
        req.value  = s_tdata[47:16];
        req.px     = s_tdata[59:48];
        req.py     = s_tdata[71:60];
    end

    // front end: coordinate mapping, cell, weights and store addresses
    bts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_tvalid),
        .i_req   (req),
        .o_ready (s_tready),
        .i_space (q_space),
        .o_push  (f_push),
        .o_job   (f_job)
    );

    // short queue decoupling the two halves
    bts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_job),
        .o_space (q_space),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    // back end: banked texel store, horizontal then vertical blend
    bts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_pop    (b_pop),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_x      (o_x),
        .o_y      (o_y),
        .o_color  (o_color)
    );

    assign m_tdata = {o_color, o_y, o_x};

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> q_space)
        else $error("queue push while full");

    // the back end only pops a queue that holds an entry
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |-> q_valid)
        else $error("queue pop while empty");

    // a stalled result keeps the back end from popping
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |-> !b_pop)
        else $error("pop while result stalled");

endmodule

// ===== dv/bilinear_texture_sampler_checker.sv =====
`timescale 1ns / 1ps
module bilinear_texture_sampler_checker import bts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] color;
    } t_pixel;

    logic [31:0] texels [0:65535];
    t_cfg        regs;
    t_pixel      pixels_due[$];
    int          errors;

    assign o_errors = errors;

    function automatic longint tex_coord(logic [11:0] pix, logic [12:0] scr,
                                         logic [15:0] off, logic [15:0] zoom,
                                         logic [8:0] tsize);
        longint dv, norm, o, prod;
        dv = (scr == 0) ? 1 : longint'(scr);
        if (dv > 4096) dv = 4096;
        norm = (longint'(pix) <<< 16) / dv;
        o    = longint'($signed(off)) * 16;
        prod = (norm + o) * longint'(zoom) * longint'(tsize);
        return (prod >>> 12) - 32768;
    endfunction

    // neighbours off the texture read as zero; address wraps at store depth
    function automatic logic [31:0] texel_at(longint col, longint row);
        longint addr;
        if (col < 0 || row < 0 || col >= longint'(regs.tex_w) || row >= longint'(regs.tex_h))
            return 32'd0;
        addr = row * longint'(regs.tex_w) + col;
        return texels[addr[15:0]];
    endfunction

    function automatic logic [31:0] lerp_argb(logic [31:0] a, logic [31:0] b, int w);
        logic [31:0] res;
        int c;
        for (int k = 0; k < 4; k++) begin
            c = (int'(a[8*k +: 8]) * (255 - w) + int'(b[8*k +: 8]) * w) / 255;
            res[8*k +: 8] = c[7:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] filtered_color(logic [11:0] px, logic [11:0] py);
        longint u, v, cx, cy;
        int wx, wy;
        logic [31:0] top, bot;
        u  = tex_coord(px, regs.scr_w, regs.off_x, regs.zoom_x, regs.tex_w);
        v  = tex_coord(py, regs.scr_h, regs.off_y, regs.zoom_y, regs.tex_h);
        cx = u >>> 16;
        cy = v >>> 16;
        wx = int'(((u & 65535) * 255) >>> 16);
        wy = int'(((v & 65535) * 255) >>> 16);
        top = lerp_argb(texel_at(cx, cy), texel_at(cx + 1, cy), wx);
        bot = lerp_argb(texel_at(cx, cy + 1), texel_at(cx + 1, cy + 1), wx);
        return lerp_argb(top, bot, wy);
    endfunction

    task automatic report(string what, logic [55:0] got, logic [55:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    initial begin
        errors    = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (!i_rst_n) begin
            regs.tex_w  <= 9'd256;
            regs.tex_h  <= 9'd256;
            regs.scr_w  <= 13'd640;
            regs.scr_h  <= 13'd480;
            regs.off_x  <= '0;
            regs.off_y  <= '0;
            regs.zoom_x <= 16'd4096;
            regs.zoom_y <= 16'd4096;
            pixels_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TEX_W:  regs.tex_w  <= i_cfg_wdata[8:0];
                    CFG_TEX_H:  regs.tex_h  <= i_cfg_wdata[8:0];
                    CFG_SCR_W:  regs.scr_w  <= i_cfg_wdata[12:0];
                    CFG_SCR_H:  regs.scr_h  <= i_cfg_wdata[12:0];
                    CFG_OFF_X:  regs.off_x  <= i_cfg_wdata;
                    CFG_OFF_Y:  regs.off_y  <= i_cfg_wdata;
                    CFG_ZOOM_X: regs.zoom_x <= i_cfg_wdata;
                    CFG_ZOOM_Y: regs.zoom_y <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (t_action'(s_tuser[0]) == ACT_WRITE) begin
                    texels[s_tdata[15:0]] = s_tdata[47:16];
                end else begin
                    want.x     = s_tdata[59:48];
                    want.y     = s_tdata[71:60];
                    want.color = filtered_color(s_tdata[59:48], s_tdata[71:60]);
                    pixels_due.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.x     = m_tdata[11:0];
                got.y     = m_tdata[23:12];
                got.color = m_tdata[55:24];
                if (pixels_due.size() == 0) begin
                    report("unexpected pixel", m_tdata, '0);
                end else begin
                    want = pixels_due.pop_front();
                    if (got.x != want.x)
                        report("out_x", got.x, want.x);
                    if (got.y != want.y)
                        report("out_y", got.y, want.y);
                    if (got.color != want.color)
                        report("color", got.color, want.color);
                end
            end
        end
        o_pending <= pixels_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import bts_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;    // [15:0] texel_index, [47:16] texel_value,
                                  // [59:48] pixel_x, [71:60] pixel_y
    logic [0:0]  s_tuser = '0;    // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // [11:0] out_x, [23:12] out_y, [55:24] color
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    int errors, pending;
    int idle_mode = 0;            // 0: sender 23 / receiver 84, 1: swapped, 2: no idling
    int quiet_cycles = 0;
    bit written [0:65535];
    int sw;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bilinear_texture_sampler_core uut (.*);

    bilinear_texture_sampler_checker checker_i (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure
    always @(negedge i_clk) begin
        case (idle_mode)
            0:       m_tready <= ($urandom_range(99) >= 84);
            1:       m_tready <= ($urandom_range(99) >= 23);
            default: m_tready <= 1'b1;
        endcase
    end

    // watchdog: cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("** bilinear_texture_sampler_core: FAILED **");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send(t_action act, logic [15:0] idx, logic [31:0] val,
                        logic [11:0] px, logic [11:0] py);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 84 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {py, px, val, idx};
        if (act == ACT_WRITE) written[idx] = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic sample_px(logic [11:0] px, logic [11:0] py);
        send(ACT_SAMPLE, 16'($urandom), $urandom, px, py);
    endtask

    // block is idle: no pixel due and the pipeline drained of texel writes
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic configure(int w, int h, int scw, int sch, int ox, int oy, int zx, int zy);
        int vals [8];
        vals = '{w, h, scw, sch, ox, oy, zx, zy};
        settle();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(i);
            i_cfg_wdata <= vals[i][15:0];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        sw = scw;
        // every texel a sample can reach must hold data first
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                int a;
                a = (r * w + c) & 16'hFFFF;
                if (!written[a])
                    send(ACT_WRITE, a[15:0], $urandom, 12'($urandom), 12'($urandom));
            end
    endtask

    // samples mostly with both coordinates up to the screen width, some anywhere
    task automatic random_traffic(int n);
        int lim;
        lim = (sw == 0) ? 1 : (sw > 4095) ? 4095 : sw;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send(ACT_WRITE, 16'($urandom), $urandom, 12'($urandom), 12'($urandom));
            else if ($urandom_range(7) == 0)
                sample_px(12'($urandom), 12'($urandom));
            else
                sample_px(12'($urandom_range(lim)), 12'($urandom_range(lim)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: small texture, corners and extremes of the pixel fields
        configure(4, 4, 16, 16, 0, 0, 4096, 4096);
        sample_px(0, 0);
        sample_px(12'hFFF, 12'hFFF);
        sample_px(12'hFFF, 0);
        sample_px(0, 12'hFFF);
        sample_px(8, 8);
        sample_px(15, 15);
        sample_px(16, 16);
        send(ACT_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
        send(ACT_WRITE, 16'h0005, 32'h0000_0000, 0, 0);
        sample_px(6, 6);
        sample_px(2, 10);
        random_traffic(30);

        // wide single-row texture, full screen divisor, max vertical zoom
        configure(256, 1, 4096, 1, 0, 0, 4096, 65535);
        sample_px(0, 0);
        sample_px(4095, 0);
        random_traffic(30);

        // tall single-column texture; zero and oversized screen, offset extremes
        configure(1, 256, 0, 8191, 32767, -32768, 0, 4096);
        random_traffic(30);

        idle_mode = 1;
        // zero-size texture: everything off the texture
        configure(0, 5, 640, 480, $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(65535));
        random_traffic(20);

        // width beyond the nominal texture size
        configure(300, 1, 8191, 3, -100, 50, 65535, 2048);
        random_traffic(40);

        configure(3, 7, $urandom_range(1, 64), $urandom_range(1, 64),
                  $urandom_range(0, 800) - 400, $urandom_range(0, 800) - 400,
                  $urandom_range(1024, 16384), $urandom_range(1024, 16384));
        random_traffic(40);

        idle_mode = 2;
        configure(16, 16, 100, 100, 0, 0, 4096, 4096);
        random_traffic(50);

        configure(2, 2, $urandom_range(1, 32), $urandom_range(1, 32),
                  $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(65535));
        random_traffic(50);

        settle();
        if (errors == 0)
            $display("** bilinear_texture_sampler_core: PASSED **");
        else
            $display("** bilinear_texture_sampler_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bts_pkg.sv
design/bts_div.sv
design/bts_front.sv
design/bts_queue.sv
design/bts_back.sv
design/bilinear_texture_sampler_core.sv
dv/bilinear_texture_sampler_checker.sv
dv/testbench.sv
